// ----- rtl/hmc_pkg.sv -----
// hmc_pkg: shared types and constants of the heater mode controller
`default_nettype none

package hmc_pkg;

    // operating modes; code 3 (MODE_NONE) is no mode: as the current mode it falls back to off
    typedef enum logic [1:0] {
        MD_OFF     = 2'd0,
        MD_AUTO    = 2'd1,
        MD_BOOST   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // relay control state
    typedef enum logic [1:0] {
        CTRL_IDLE    = 2'd0,
        CTRL_HEATING = 2'd1,
        CTRL_ERROR   = 2'd2
    } t_ctrl;

    // request opcodes
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_MODE = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SETPOINT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HYSTERESIS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOOST_MIN  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL   = 2'd3;

    // field widths
    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned HYST_W     = 11;
    localparam int unsigned BOOST_W    = 11;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned BAND_W     = TEMP_W + 2;

    // boost length in ms fits 27 bits (1440 min * 60000 < 2^27)
    localparam int unsigned BOOST_MS_W    = 27;
    localparam int unsigned MS_PER_MINUTE = 60000;

    // register reset values
    localparam logic signed [TEMP_W-1:0] SETPOINT_RESET   = 15'sd2100;
    localparam logic [HYST_W-1:0]        HYSTERESIS_RESET = 11'd50;
    localparam int unsigned              BOOST_MIN_RESET  = 30;
    localparam logic [INTERVAL_W-1:0]    INTERVAL_RESET   = 16'd2000;
    localparam logic [BOOST_MS_W-1:0]    BOOST_MS_RESET   =
        BOOST_MS_W'(BOOST_MIN_RESET * MS_PER_MINUTE);

    // one result item
    typedef struct packed {
        logic  heater_on;
        t_ctrl control_state;
        t_mode active_mode;
        logic  evaluated;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/hmc_out_buf.sv -----
// hmc_out_buf: two-entry result buffer between the controller and the output channel
`default_nettype none

module hmc_out_buf
    import hmc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/heater_mode_controller.sv -----
// heater_mode_controller: thermostat with OFF, AUTO and BOOST modes and a boost timer
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  request  | in        | i_valid / o_stall  | opcode, now_ms, temperature, sensor_ok,
//           |           |                    | new_mode
//  result   | out       | o_valid / i_stall  | heater_on, control_state, active_mode,
//           |           |                    | evaluated
//  config   | in        | i_cfg_wr_en        | i_cfg_addr, i_cfg_wdata
//
// one request per cycle while o_stall is low; its result is written into the output buffer on acceptance
// every request is evaluated combinationally straight into the state registers;
// the result goes into a two-entry buffer, so a request is taken while one result waits
// o_stall rises only when both buffer entries hold results not yet taken
// synchronous active-low reset restores all state and the register defaults
`default_nettype none

module heater_mode_controller
    import hmc_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_opcode,
    input  wire logic [NOW_W-1:0]        i_now_ms,
    input  wire logic signed [TEMP_W-1:0] i_temperature,
    input  wire logic                    i_sensor_ok,
    input  wire logic [1:0]              i_new_mode,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_heater_on,
    output logic [1:0]                   o_control_state,
    output logic [1:0]                   o_active_mode,
    output logic                         o_evaluated
);

    // configuration registers
    logic signed [TEMP_W-1:0]  r_setpoint;
    logic [HYST_W-1:0]         r_hysteresis;
    logic [BOOST_MS_W-1:0]     r_boost_ms;
    logic [INTERVAL_W-1:0]     r_interval;

    // controller state
    t_mode                 r_mode_now, n_mode_now;
    t_mode                 r_mode_req, n_mode_req;
    t_mode                 r_mode_entered, n_mode_entered;
    t_ctrl                 r_ctrl, n_ctrl;
    logic                  r_relay, n_relay;
    logic [TIME_BITS-1:0]  r_last_eval, n_last_eval;
    logic [TIME_BITS-1:0]  r_boost_end, n_boost_end;
    logic                  r_boost_pend, n_boost_pend;
    logic                  n_evaluated;

    logic                  w_accept;
    logic                  w_buf_full;
    t_result               w_result;
    t_result               w_out;

    logic [TIME_BITS+NOW_W-1:0]      w_now_ext;
    logic [TIME_BITS-1:0]            w_now;
    logic [TIME_BITS+BOOST_MS_W-1:0] w_boost_ext;
    logic [TIME_BITS-1:0]            w_since_eval;
    logic [TIME_BITS+INTERVAL_W-1:0] w_since_ext;
    logic [TIME_BITS+INTERVAL_W-1:0] w_interval_ext;
    logic                            w_gate;
    logic [TIME_BITS-1:0]            w_boost_left;
    logic signed [BAND_W-1:0]        w_band_lo;
    logic signed [BAND_W-1:0]        w_band_hi;
    logic signed [BAND_W-1:0]        w_temp_ext;
    logic                            w_change;

    assign w_accept = i_valid && !w_buf_full;
    assign o_stall  = w_buf_full;

    // configuration writes, boost length kept in milliseconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= SETPOINT_RESET;
            r_hysteresis <= HYSTERESIS_RESET;
            r_boost_ms   <= BOOST_MS_RESET;
            r_interval   <= INTERVAL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SETPOINT:   r_setpoint   <= $signed(i_cfg_wdata[TEMP_W-1:0]);
                CFG_HYSTERESIS: r_hysteresis <= i_cfg_wdata[HYST_W-1:0];
                CFG_BOOST_MIN:  r_boost_ms   <=
                    {{(BOOST_MS_W-BOOST_W){1'b0}}, i_cfg_wdata[BOOST_W-1:0]}
                    * BOOST_MS_W'(MS_PER_MINUTE);
                CFG_INTERVAL:   r_interval   <= i_cfg_wdata[INTERVAL_W-1:0];
                default:        r_interval   <= r_interval;
            endcase
        end
    end

    // time base, interval gate and hysteresis band
    always_comb begin
        w_now_ext      = {{TIME_BITS{1'b0}}, i_now_ms};
        w_now          = w_now_ext[TIME_BITS-1:0];
        w_boost_ext    = {{TIME_BITS{1'b0}}, r_boost_ms};
        w_since_eval   = w_now - r_last_eval;
        w_since_ext    = {{INTERVAL_W{1'b0}}, w_since_eval};
        w_interval_ext = {{TIME_BITS{1'b0}}, r_interval};
        w_gate         = (w_since_ext >= w_interval_ext);
        w_temp_ext     = {{2{i_temperature[TEMP_W-1]}}, i_temperature};
        w_band_lo      = {{2{r_setpoint[TEMP_W-1]}}, r_setpoint}
                       - $signed({{(BAND_W-HYST_W){1'b0}}, r_hysteresis});
        w_band_hi      = {{2{r_setpoint[TEMP_W-1]}}, r_setpoint}
                       + $signed({{(BAND_W-HYST_W){1'b0}}, r_hysteresis});
        w_change       = (r_mode_req != r_mode_now);
    end

    // next state for one request
    always_comb begin
        n_mode_now     = r_mode_now;
        n_mode_req     = r_mode_req;
        n_mode_entered = r_mode_entered;
        n_ctrl         = r_ctrl;
        n_relay        = r_relay;
        n_last_eval    = r_last_eval;
        n_boost_end    = r_boost_end;
        n_boost_pend   = r_boost_pend;
        n_evaluated    = 1'b0;
        w_boost_left   = '0;

        if (i_opcode == OP_SET_MODE) begin
            n_mode_req = t_mode'(i_new_mode);
        end else if (w_gate) begin
            n_last_eval = w_now;
            n_evaluated = 1'b1;
            unique case (r_mode_now)
                MD_OFF: begin
                    if (r_mode_entered != MD_OFF) begin
                        n_relay        = 1'b0;
                        n_ctrl         = CTRL_IDLE;
                        n_mode_entered = MD_OFF;
                    end
                    if (!i_sensor_ok) begin
                        n_relay = 1'b0;
                        n_ctrl  = CTRL_ERROR;
                    end else begin
                        if (n_ctrl == CTRL_ERROR) begin
                            n_ctrl = CTRL_IDLE;
                        end
                        if (w_change) begin
                            n_mode_now     = r_mode_req;
                            n_mode_entered = MODE_NONE;
                        end
                    end
                end
                MD_BOOST: begin
                    // on entry: start the timer unless one is still pending
                    if (r_mode_entered != MD_BOOST) begin
                        if (!r_boost_pend) begin
                            n_boost_end  = w_now + w_boost_ext[TIME_BITS-1:0];
                            n_boost_pend = 1'b1;
                        end
                        n_relay        = 1'b1;
                        n_ctrl         = CTRL_HEATING;
                        n_mode_entered = MD_BOOST;
                    end
                    w_boost_left = w_now - n_boost_end;
                    if (!i_sensor_ok) begin
                        n_relay = 1'b0;
                        n_ctrl  = CTRL_ERROR;
                    end else begin
                        if (n_ctrl == CTRL_ERROR) begin
                            n_relay = 1'b1;
                            n_ctrl  = CTRL_HEATING;
                        end
                        // expiry: now at or past the end within half the range
                        if (n_boost_pend && !w_boost_left[TIME_BITS-1]) begin
                            n_boost_pend   = 1'b0;
                            n_boost_end    = '0;
                            n_mode_req     = MD_AUTO;
                            n_mode_now     = MD_AUTO;
                            n_mode_entered = MODE_NONE;
                        end else if (w_change) begin
                            n_boost_pend   = 1'b0;
                            n_boost_end    = '0;
                            n_mode_now     = r_mode_req;
                            n_mode_entered = MODE_NONE;
                        end
                    end
                end
                MD_AUTO: begin
                    n_mode_entered = MD_AUTO;
                    if (!i_sensor_ok) begin
                        n_relay = 1'b0;
                        n_ctrl  = CTRL_ERROR;
                    end else begin
                        if (n_ctrl == CTRL_ERROR) begin
                            n_ctrl = r_relay ? CTRL_HEATING : CTRL_IDLE;
                        end
                        // switch only on band edges
                        if (w_change) begin
                            n_mode_now     = r_mode_req;
                            n_mode_entered = MODE_NONE;
                        end else if (n_ctrl != CTRL_HEATING && w_temp_ext <= w_band_lo) begin
                            n_relay = 1'b1;
                            n_ctrl  = CTRL_HEATING;
                        end else if (n_ctrl != CTRL_IDLE && w_temp_ext >= w_band_hi) begin
                            n_relay = 1'b0;
                            n_ctrl  = CTRL_IDLE;
                        end
                    end
                end
                default: begin
                    n_mode_now = MD_OFF;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_now     <= MD_AUTO;
            r_mode_req     <= MD_AUTO;
            r_mode_entered <= MODE_NONE;
            r_ctrl         <= CTRL_IDLE;
            r_relay        <= 1'b0;
            r_last_eval    <= '0;
            r_boost_end    <= '0;
            r_boost_pend   <= 1'b0;
        end else if (w_accept) begin
            r_mode_now     <= n_mode_now;
            r_mode_req     <= n_mode_req;
            r_mode_entered <= n_mode_entered;
            r_ctrl         <= n_ctrl;
            r_relay        <= n_relay;
            r_last_eval    <= n_last_eval;
            r_boost_end    <= n_boost_end;
            r_boost_pend   <= n_boost_pend;
        end
    end

    // result of this request
    always_comb begin
        w_result.heater_on     = n_relay;
        w_result.control_state = n_ctrl;
        w_result.active_mode   = n_mode_now;
        w_result.evaluated     = n_evaluated;
    end

    hmc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (w_out)
    );

    assign o_heater_on     = w_out.heater_on;
    assign o_control_state = w_out.control_state;
    assign o_active_mode   = w_out.active_mode;
    assign o_evaluated     = w_out.evaluated;

endmodule

`default_nettype wire

// ----- dv/tb_heater_mode_controller.sv -----
// tb_heater_mode_controller: directed and random checks of the heater mode controller
`default_nettype none

module tb_heater_mode_controller;
    import hmc_pkg::*;

    logic                        i_clk;
    logic                        i_rst_n         = 1'b0;
    logic                        i_cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr      = CFG_SETPOINT;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata     = '0;
    logic                        i_valid         = 1'b0;
    logic                        i_opcode        = OP_TICK;
    logic [NOW_W-1:0]            i_now_ms        = '0;
    logic signed [TEMP_W-1:0]    i_temperature   = '0;
    logic                        i_sensor_ok     = 1'b1;
    logic [1:0]                  i_new_mode      = MD_AUTO;
    logic                        i_stall         = 1'b0;
    logic                        o_stall;
    logic                        o_valid;
    logic                        o_heater_on;
    logic [1:0]                  o_control_state;
    logic [1:0]                  o_active_mode;
    logic                        o_evaluated;

    // register copies as the block should hold them
    logic signed [TEMP_W-1:0]    cfg_setpoint    = SETPOINT_RESET;
    logic [HYST_W-1:0]           cfg_hyst        = HYSTERESIS_RESET;
    logic [BOOST_W-1:0]          cfg_boost_min   = BOOST_W'(BOOST_MIN_RESET);
    logic [INTERVAL_W-1:0]       cfg_interval    = INTERVAL_RESET;

    // controller state as the block should hold it
    t_mode                       st_mode         = MD_AUTO;
    t_mode                       st_req          = MD_AUTO;
    t_mode                       st_entered      = MODE_NONE;
    t_ctrl                       st_ctrl         = CTRL_IDLE;
    logic                        st_relay        = 1'b0;
    logic [NOW_W-1:0]            st_last_eval    = '0;
    logic [NOW_W-1:0]            st_boost_end    = '0;
    logic                        st_boost_armed  = 1'b0;

    t_result                     status_q[$];
    int unsigned                 mismatch_count  = 0;
    int unsigned                 tx_idle_pct     = 0;
    int unsigned                 rx_idle_pct     = 0;
    int unsigned                 rx_hold_cycles  = 0;
    logic [NOW_W-1:0]            now_cursor      = '0;

    heater_mode_controller u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (i_opcode),
        .i_now_ms        (i_now_ms),
        .i_temperature   (i_temperature),
        .i_sensor_ok     (i_sensor_ok),
        .i_new_mode      (i_new_mode),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_heater_on     (o_heater_on),
        .o_control_state (o_control_state),
        .o_active_mode   (o_active_mode),
        .o_evaluated     (o_evaluated)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("tb_heater_mode_controller: done, errors");
        $finish;
    end

    // next relay status for one request, updates the controller copy
    function automatic t_result predict_relay_status(logic op, logic [NOW_W-1:0] now,
            logic signed [TEMP_W-1:0] temp, logic ok, logic [1:0] nm);
        t_result          res;
        logic [NOW_W-1:0] since;
        logic [NOW_W-1:0] past_end;
        logic             change;
        int               tmp;
        int               sp;
        int               hy;
        res.evaluated = 1'b0;
        if (op == OP_SET_MODE) begin
            st_req = t_mode'(nm);
        end else begin
            since = now - st_last_eval;
            if (since >= NOW_W'(cfg_interval)) begin
                st_last_eval  = now;
                res.evaluated = 1'b1;
                change = (st_req != st_mode);
                tmp = temp;
                sp  = cfg_setpoint;
                hy  = cfg_hyst;
                case (st_mode)
                    MD_OFF: begin
                        if (st_entered != MD_OFF) begin
                            st_relay   = 1'b0;
                            st_ctrl    = CTRL_IDLE;
                            st_entered = MD_OFF;
                        end
                        if (!ok) begin
                            st_relay = 1'b0;
                            st_ctrl  = CTRL_ERROR;
                        end else begin
                            if (st_ctrl == CTRL_ERROR) st_ctrl = CTRL_IDLE;
                            if (change) begin
                                st_mode    = st_req;
                                st_entered = MODE_NONE;
                            end
                        end
                    end
                    MD_BOOST: begin
                        // first evaluation in boost arms the timer unless one is pending
                        if (st_entered != MD_BOOST) begin
                            if (!st_boost_armed) begin
                                st_boost_end   = now + NOW_W'(cfg_boost_min) * MS_PER_MINUTE;
                                st_boost_armed = 1'b1;
                            end
                            st_relay   = 1'b1;
                            st_ctrl    = CTRL_HEATING;
                            st_entered = MD_BOOST;
                        end
                        past_end = now - st_boost_end;
                        if (!ok) begin
                            st_relay = 1'b0;
                            st_ctrl  = CTRL_ERROR;
                        end else begin
                            if (st_ctrl == CTRL_ERROR) begin
                                st_relay = 1'b1;
                                st_ctrl  = CTRL_HEATING;
                            end
                            // expiry wins over a pending request and rewrites it
                            if (st_boost_armed && !past_end[NOW_W-1]) begin
                                st_boost_armed = 1'b0;
                                st_boost_end   = '0;
                                st_req         = MD_AUTO;
                                st_mode        = MD_AUTO;
                                st_entered     = MODE_NONE;
                            end else if (change) begin
                                st_boost_armed = 1'b0;
                                st_boost_end   = '0;
                                st_mode        = st_req;
                                st_entered     = MODE_NONE;
                            end
                        end
                    end
                    MD_AUTO: begin
                        st_entered = MD_AUTO;
                        if (!ok) begin
                            st_relay = 1'b0;
                            st_ctrl  = CTRL_ERROR;
                        end else begin
                            if (st_ctrl == CTRL_ERROR)
                                st_ctrl = st_relay ? CTRL_HEATING : CTRL_IDLE;
                            // hysteresis band, switch only on the edges
                            if (change) begin
                                st_mode    = st_req;
                                st_entered = MODE_NONE;
                            end else if (st_ctrl != CTRL_HEATING && tmp <= sp - hy) begin
                                st_relay = 1'b1;
                                st_ctrl  = CTRL_HEATING;
                            end else if (st_ctrl != CTRL_IDLE && tmp >= sp + hy) begin
                                st_relay = 1'b0;
                                st_ctrl  = CTRL_IDLE;
                            end
                        end
                    end
                    default: st_mode = MD_OFF;
                endcase
            end
        end
        res.heater_on     = st_relay;
        res.control_state = st_ctrl;
        res.active_mode   = st_mode;
        return res;
    endfunction

    task automatic report_field(string field, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // result check against the oldest expectation, then record the accepted request
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %0d %0d %0d %0d", $time,
                             o_heater_on, o_control_state, o_active_mode, o_evaluated);
                    mismatch_count++;
                end else begin
                    want = status_q.pop_front();
                    report_field("heater_on", {1'b0, want.heater_on}, {1'b0, o_heater_on});
                    report_field("control_state", want.control_state, o_control_state);
                    report_field("active_mode", want.active_mode, o_active_mode);
                    report_field("evaluated", {1'b0, want.evaluated}, {1'b0, o_evaluated});
                end
            end
            if (i_valid && o_stall === 1'b0)
                status_q.push_back(predict_relay_status(i_opcode, i_now_ms, i_temperature,
                                                        i_sensor_ok, i_new_mode));
        end
    end

    // result side stall: long hold-off when asked, else random
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_stall <= 1'b1;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // offer one request and wait for it to be taken; valid stays high afterwards
    task automatic send_req(logic op, logic [NOW_W-1:0] now, logic [TEMP_W-1:0] temp,
                            logic ok, logic [1:0] nm);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_now_ms      <= now;
        i_temperature <= temp;
        i_sensor_ok   <= ok;
        i_new_mode    <= nm;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    // let the next edge pass first so the last accepted request is already queued
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // all four registers, written back to back while idle
    task automatic set_regs(logic [CFG_DATA_W-1:0] sp, logic [CFG_DATA_W-1:0] hy,
                            logic [CFG_DATA_W-1:0] bm, logic [CFG_DATA_W-1:0] iv);
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= CFG_SETPOINT;
        i_cfg_wdata <= sp;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HYSTERESIS;
        i_cfg_wdata <= hy;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_BOOST_MIN;
        i_cfg_wdata <= bm;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_INTERVAL;
        i_cfg_wdata <= iv;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_setpoint  = sp[TEMP_W-1:0];
        cfg_hyst      = hy[HYST_W-1:0];
        cfg_boost_min = bm[BOOST_W-1:0];
        cfg_interval  = iv[INTERVAL_W-1:0];
    endtask

    // mostly ticks past the gate with temperatures around the band, some noise
    task automatic send_random_item();
        int unsigned      pick;
        int               t;
        int               sp;
        int               hy;
        logic [NOW_W-1:0] step;
        logic             ok;
        pick = $urandom_range(99);
        if (pick < 12) begin
            send_req(OP_SET_MODE, $urandom, TEMP_W'($urandom), 1'($urandom_range(1)),
                     2'($urandom_range(3)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 65)
                step = cfg_interval + $urandom_range(400);
            else if (pick < 82)
                step = $urandom_range(cfg_interval);
            else if (pick < 92)
                step = $urandom_range(200000);
            else if (pick < 96)
                step = $urandom_range(32'h0800_0000);
            else
                step = $urandom;
            now_cursor = now_cursor + step;
            sp = cfg_setpoint;
            hy = cfg_hyst;
            pick = $urandom_range(99);
            if (pick < 82)
                t = sp - (hy + 150) + int'($urandom_range(2 * (hy + 150)));
            else if (pick < 92)
                t = $urandom;
            else
                case ($urandom_range(3))
                    0: t = -5500;
                    1: t = 12500;
                    2: t = -16384;
                    default: t = 16383;
                endcase
            ok = ($urandom_range(99) < 92);
            send_req(OP_TICK, now_cursor, t[TEMP_W-1:0], ok, 2'($urandom_range(3)));
        end
    endtask

    // gate edges, band edges, sensor failure, every mode, boost expiry, time wrap
    task automatic test_directed();
        send_req(OP_TICK, 32'd0, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd1999, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd2000, 15'sd2050, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd4000, 15'sd2150, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd6000, 15'h4000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd8000, 15'h3FFF, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd10000, 15'sd2000, 1'b0, MD_AUTO);
        send_req(OP_TICK, 32'd12000, 15'sd2100, 1'b1, MD_AUTO);
        send_req(OP_SET_MODE, 32'd0, 15'sd0, 1'b1, MD_OFF);
        send_req(OP_TICK, 32'd14000, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd16000, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd18000, 15'sd2000, 1'b0, MD_AUTO);
        send_req(OP_SET_MODE, 32'hFFFF_FFFF, 15'h7FFF, 1'b0, MD_BOOST);
        send_req(OP_TICK, 32'd20000, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd22000, 15'sd2000, 1'b1, MD_AUTO);
        // sensor loss mid boost keeps the end time
        send_req(OP_TICK, 32'd24000, 15'sd2000, 1'b0, MD_AUTO);
        send_req(OP_TICK, 32'd26000, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd1822000, 15'sd2000, 1'b1, MD_AUTO);
        // invalid mode request, then fall back to off
        send_req(OP_SET_MODE, 32'd0, 15'sd0, 1'b1, MODE_NONE);
        send_req(OP_TICK, 32'd1824000, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd1826000, 15'sd2000, 1'b1, MD_AUTO);
        // zero interval, zero-length boost and wrap of the millisecond time
        set_regs(CFG_DATA_W'(SETPOINT_RESET), CFG_DATA_W'(HYSTERESIS_RESET), 16'd0, 16'd0);
        send_req(OP_SET_MODE, 32'd0, 15'sd0, 1'b1, MD_BOOST);
        send_req(OP_TICK, 32'hFFFF_FFF0, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'hFFFF_FFFF, 15'sd2000, 1'b1, MD_AUTO);
        send_req(OP_TICK, 32'd5, 15'sd2000, 1'b1, MD_AUTO);
        set_regs(CFG_DATA_W'(SETPOINT_RESET), CFG_DATA_W'(HYSTERESIS_RESET),
                 CFG_DATA_W'(BOOST_MIN_RESET), INTERVAL_RESET);
        now_cursor = 32'd5;
    endtask

    task automatic test_random_traffic(int unsigned count);
        repeat (count) send_random_item();
    endtask

    // register extremes, out of range writes truncate, then a random setting
    task automatic test_config_sweep();
        set_regs(16'(-5500), 16'd0, 16'd0, 16'd0);
        repeat (28) send_random_item();
        set_regs(16'd12500, 16'd2000, 16'd1440, 16'hFFFF);
        repeat (28) send_random_item();
        set_regs(16'h4000, 16'hFFFF, 16'd1, 16'd1);
        repeat (28) send_random_item();
        set_regs(16'(int'($urandom_range(18000)) - 5500), 16'($urandom_range(2000)),
                 16'($urandom_range(3)), 16'($urandom_range(5000)));
        repeat (28) send_random_item();
    endtask

    // long result hold-off while requests keep coming, so the input stalls
    task automatic test_stall_fill();
        rx_hold_cycles = 60;
        repeat (24) send_random_item();
    endtask

    // sender stops until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (10) send_random_item();
        wait_drain();
        repeat (10) send_random_item();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 17;
        rx_idle_pct = 76;
        test_directed();
        test_random_traffic(150);
        test_config_sweep();

        tx_idle_pct = 76;
        rx_idle_pct = 17;
        test_random_traffic(110);
        test_sender_pause();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_stall_fill();
        test_random_traffic(110);

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_heater_mode_controller: done, clean");
        else
            $display("tb_heater_mode_controller: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
